### hw/rtl/dcc_pkg.sv
package dcc_pkg;

   localparam int PREAMBLE_BITS   = 14;
   localparam int MAX_FRAME_BYTES = 6;
   localparam int QUEUE_DEPTH     = 2;

   localparam int PRE_W      = $clog2(PREAMBLE_BITS + 3);
   localparam int IDX_W      = $clog2(MAX_FRAME_BYTES);
   localparam int BYTE_POS_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int FILL_W     = $clog2(MAX_FRAME_BYTES);
   localparam int PIDX_W     = $clog2(MAX_FRAME_BYTES - 1);
   localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PRE_W-1:0] PRE_LOAD = PRE_W'(PREAMBLE_BITS + 2);

   localparam logic [15:0] ONE_HALF_RESET  = 16'h02B7;
   localparam logic [15:0] ZERO_HALF_RESET = 16'h04AF;

   localparam logic [7:0] IDLE_BYTE_ADDR = 8'hFF;
   localparam logic [7:0] IDLE_BYTE_DATA = 8'h00;
   localparam logic [7:0] IDLE_BYTE_XOR  = 8'hFF;
   localparam int         IDLE_LEN       = 3;

   localparam int RSP_TDATA_W = 24;

   typedef enum logic {
      CSR_ONE_HALF  = 1'b0,
      CSR_ZERO_HALF = 1'b1
   } csr_index_type;

   typedef enum logic {
      ITEM_TICK = 1'b0,
      ITEM_LOAD = 1'b1
   } item_kind_type;

   typedef enum logic [1:0] {
      PH_PREAMBLE = 2'd0,
      PH_START    = 2'd1,
      PH_DATA     = 2'd2
   } tx_phase_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    byte_value;
      logic          byte_last;
   } queue_item_type;

   typedef struct packed {
      logic        load_dropped;
      logic        pending_free;
      logic [15:0] half_period;
      logic        bit_value;
      logic        bit_start;
   } result_type;

endpackage

### hw/rtl/dcc_front.sv
module dcc_front
   import dcc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,  // byte_value
   input  logic           req_tlast,  // byte_last
   input  logic           req_tuser,  // mode
   output logic           q_valid,
   output queue_item_type q_item,
   input  logic           q_pop
);

   queue_item_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   queue_item_type    new_item;

   assign req_tready = (count_ff < QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_item     = entry_ff[rd_ptr_ff];

   // classify the incoming transaction
   always_comb begin
      new_item.kind       = req_tuser ? ITEM_LOAD : ITEM_TICK;
      new_item.byte_value = req_tdata;
      new_item.byte_last  = req_tlast;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !q_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (q_pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/dcc_back.sv
module dcc_back
   import dcc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_we,
   input  logic           csr_index,
   input  logic [15:0]    csr_wdata,
   input  logic           q_valid,
   input  queue_item_type q_item,
   output logic           q_pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output result_type     rsp_data
);

   logic [15:0] one_half_ff;
   logic [15:0] zero_half_ff;

   logic                  half_phase_ff, half_phase_in;
   logic                  upcoming_ff, upcoming_in;
   tx_phase_type          tx_phase_ff, tx_phase_in;
   logic [PRE_W-1:0]      preamble_left_ff, preamble_left_in;
   logic [BYTE_POS_W-1:0] byte_pos_ff, byte_pos_in;
   logic [2:0]            bit_pos_ff, bit_pos_in;
   logic [7:0]            frame_ff [MAX_FRAME_BYTES];
   logic [7:0]            frame_in [MAX_FRAME_BYTES];
   logic [BYTE_POS_W-1:0] frame_len_ff, frame_len_in;
   logic [7:0]            pend_ff [MAX_FRAME_BYTES-1];
   logic [7:0]            pend_in [MAX_FRAME_BYTES-1];
   logic [FILL_W-1:0]     pend_fill_ff, pend_fill_in;
   logic                  pend_ready_ff, pend_ready_in;
   logic [7:0]            pend_xor_ff, pend_xor_in;

   logic                  rsp_valid_ff;
   result_type            rsp_data_ff, result;

   logic                  bit_step;
   logic                  pre_done;
   logic                  byte_done;
   logic                  frame_done;
   logic [BYTE_POS_W-1:0] byte_pos_next;
   logic [7:0]            cur_byte;

   assign q_pop     = q_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign bit_step      = (q_item.kind == ITEM_TICK) && half_phase_ff;
   assign pre_done      = (preamble_left_ff <= PRE_W'(1));
   assign byte_done     = (bit_pos_ff == 3'd0);
   assign byte_pos_next = byte_pos_ff + BYTE_POS_W'(1);
   assign frame_done    = (byte_pos_next >= frame_len_ff);
   assign cur_byte      = (byte_pos_ff < BYTE_POS_W'(MAX_FRAME_BYTES))
                          ? frame_ff[byte_pos_ff[IDX_W-1:0]] : 8'h00;

   // transmit phase sequencing
   always_comb begin
      tx_phase_in = tx_phase_ff;
      if (bit_step) begin
         unique case (tx_phase_ff)
            PH_PREAMBLE: begin
               if (pre_done) begin
                  tx_phase_in = PH_START;
               end
            end
            PH_START: begin
               tx_phase_in = PH_DATA;
            end
            PH_DATA: begin
               if (byte_done) begin
                  tx_phase_in = frame_done ? PH_PREAMBLE : PH_START;
               end
            end
            default: begin
               tx_phase_in = PH_PREAMBLE;
            end
         endcase
      end
   end

   always_comb begin
      half_phase_in    = half_phase_ff;
      upcoming_in      = upcoming_ff;
      preamble_left_in = preamble_left_ff;
      byte_pos_in      = byte_pos_ff;
      bit_pos_in       = bit_pos_ff;
      frame_in         = frame_ff;
      frame_len_in     = frame_len_ff;
      pend_in          = pend_ff;
      pend_fill_in     = pend_fill_ff;
      pend_ready_in    = pend_ready_ff;
      pend_xor_in      = pend_xor_ff;
      result           = '0;

      if (q_item.kind == ITEM_TICK) begin
         half_phase_in = ~half_phase_ff;
         if (half_phase_ff) begin
            result.bit_start   = 1'b1;
            result.bit_value   = upcoming_ff;
            result.half_period = upcoming_ff ? one_half_ff : zero_half_ff;
            unique case (tx_phase_ff)
               PH_PREAMBLE: begin
                  upcoming_in = 1'b1;
                  if (pre_done) begin
                     byte_pos_in      = '0;
                     preamble_left_in = PRE_LOAD;
                     if (!pend_ready_ff) begin
                        frame_in[0]  = IDLE_BYTE_ADDR;
                        frame_in[1]  = IDLE_BYTE_DATA;
                        frame_in[2]  = IDLE_BYTE_XOR;
                        frame_len_in = BYTE_POS_W'(IDLE_LEN);
                     end else begin
                        for (int i = 0; i < MAX_FRAME_BYTES - 1; i++) begin
                           if (FILL_W'(i) < pend_fill_ff) begin
                              frame_in[i] = pend_ff[i];
                           end
                        end
                        frame_in[pend_fill_ff[IDX_W-1:0]] = pend_xor_ff;
                        frame_len_in  = BYTE_POS_W'(pend_fill_ff) + BYTE_POS_W'(1);
                        pend_fill_in  = '0;
                        pend_ready_in = 1'b0;
                        pend_xor_in   = 8'h00;
                     end
                  end else begin
                     preamble_left_in = preamble_left_ff - PRE_W'(1);
                  end
               end
               PH_START: begin
                  upcoming_in = 1'b0;
                  bit_pos_in  = 3'd7;
               end
               PH_DATA: begin
                  upcoming_in = cur_byte[bit_pos_ff];
                  if (byte_done) begin
                     byte_pos_in = byte_pos_next;
                  end else begin
                     bit_pos_in = bit_pos_ff - 3'd1;
                  end
               end
               default: begin
                  upcoming_in      = 1'b1;
                  preamble_left_in = PRE_LOAD;
               end
            endcase
         end
      end else begin
         priority if (pend_ready_ff) begin
            result.load_dropped = 1'b1;
         end else if (pend_fill_ff >= FILL_W'(MAX_FRAME_BYTES - 1)) begin
            result.load_dropped = 1'b1;
            pend_ready_in       = q_item.byte_last;
         end else begin
            pend_in[pend_fill_ff[PIDX_W-1:0]] = q_item.byte_value;
            pend_fill_in  = pend_fill_ff + FILL_W'(1);
            pend_xor_in   = pend_xor_ff ^ q_item.byte_value;
            pend_ready_in = q_item.byte_last;
         end
      end

      result.pending_free = (pend_fill_in == '0) && !pend_ready_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_half_ff  <= ONE_HALF_RESET;
         zero_half_ff <= ZERO_HALF_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ONE_HALF:  one_half_ff  <= csr_wdata;
            CSR_ZERO_HALF: zero_half_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // packet buffers and response data, no reset
   always_ff @(posedge clock) begin
      if (q_pop) begin
         frame_ff    <= frame_in;
         pend_ff     <= pend_in;
         rsp_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_phase_ff    <= 1'b0;
         upcoming_ff      <= 1'b1;
         tx_phase_ff      <= PH_PREAMBLE;
         preamble_left_ff <= PRE_LOAD;
         byte_pos_ff      <= '0;
         bit_pos_ff       <= 3'd7;
         frame_len_ff     <= '0;
         pend_fill_ff     <= '0;
         pend_ready_ff    <= 1'b0;
         pend_xor_ff      <= 8'h00;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (q_pop) begin
            half_phase_ff    <= half_phase_in;
            upcoming_ff      <= upcoming_in;
            tx_phase_ff      <= tx_phase_in;
            preamble_left_ff <= preamble_left_in;
            byte_pos_ff      <= byte_pos_in;
            bit_pos_ff       <= bit_pos_in;
            frame_len_ff     <= frame_len_in;
            pend_fill_ff     <= pend_fill_in;
            pend_ready_ff    <= pend_ready_in;
            pend_xor_ff      <= pend_xor_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      pend_fill_ff <= FILL_W'(MAX_FRAME_BYTES - 1))
      else $error("pending fill beyond buffer depth");

   a_load_no_bit: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_item.kind == ITEM_LOAD) |=> !rsp_data_ff.bit_start)
      else $error("load transaction started a bit");

   a_first_half: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_item.kind == ITEM_TICK && !half_phase_ff)
      |=> (!rsp_data_ff.bit_start && !rsp_data_ff.load_dropped))
      else $error("first half tick reported a bit or a drop");

   a_data_pos: assert property (@(posedge clock) disable iff (reset)
      (tx_phase_ff == PH_DATA) |-> (byte_pos_ff < frame_len_ff))
      else $error("byte position past frame length");

endmodule

### hw/rtl/dcc_packet_bit_encoder.sv
// an accepted transaction waits in the queue, then the back end executes it into a registered result
// throughput: one transaction per cycle while results are taken, set by the execute stage in the back end
// a two-entry queue between front and back keeps input flowing while a result waits
// reset: synchronous, active high; clears control state and sets compare counts to 695 / 1199
// packet buffers are not cleared; only written entries are ever read
module dcc_packet_bit_encoder
   import dcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [15:0]            csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,  // byte_value
   input  logic                   req_tlast,  // byte_last
   input  logic                   req_tuser,  // mode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // bit_start, bit_value, half_period[15:0], pending_free, load_dropped, zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic           q_valid;
   logic           q_pop;
   queue_item_type q_item;
   result_type     rsp_data;

   dcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   dcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = {(RSP_TDATA_W - $bits(result_type))'(0), rsp_data};

endmodule
